// ===== rtl/word_frequency_table_assert.svh =====
// Assertion macros shared by the word frequency table RTL.
`ifndef WORD_FREQUENCY_TABLE_ASSERT_SVH
`define WORD_FREQUENCY_TABLE_ASSERT_SVH

// Checked on every clock edge outside reset.
`define WFT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define WFT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/wft_pkg.sv =====
// Shared constants, types and character helpers of the word frequency table.
package wft_pkg;

    localparam logic [7:0] CHR_APOS   = 8'h27;
    localparam logic [7:0] CHR_HYPHEN = 8'h2D;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // Write enables of the three entry stores.
    typedef struct packed {
        logic len_we;
        logic cnt_we;
        logic chr_we;
    } wft_we_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
               (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
    endfunction

    function automatic logic is_keep_plain(input logic [7:0] c);
        return ((c >= CHR_LOWER_A) && (c <= CHR_LOWER_Z)) ||
               (c == CHR_APOS) || (c == CHR_HYPHEN);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= CHR_UPPER_A) && (c <= CHR_UPPER_Z);
    endfunction

endpackage

// ===== rtl/wft_buf.sv =====
// Buffer that holds the filtered characters of the word in progress.
module wft_buf #(
    parameter int MAX_WORD_LEN = 99
) (
    input  logic                            clk,
    input  logic                            we,
    input  logic [$clog2(MAX_WORD_LEN)-1:0] waddr,
    input  logic [7:0]                      wdata,
    input  logic [$clog2(MAX_WORD_LEN)-1:0] raddr,
    output logic [7:0]                      rdata
);

    logic [7:0] mem [MAX_WORD_LEN];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/wft_table.sv =====
// Entry stores of the table: characters, lengths and counts.
module wft_table #(
    parameter int MAX_WORD_LEN = 99,
    parameter int TABLE_DEPTH  = 256,
    parameter int COUNT_WIDTH  = 24
) (
    input  logic                                          clk,
    input  wft_pkg::wft_we_t                              we,
    input  logic [$clog2(TABLE_DEPTH)-1:0]                ent_addr,
    input  logic [$clog2(TABLE_DEPTH*MAX_WORD_LEN)-1:0]   chr_addr,
    input  logic [$clog2(MAX_WORD_LEN+1)-1:0]             len_wdata,
    input  logic [COUNT_WIDTH-1:0]                        cnt_wdata,
    input  logic [7:0]                                    chr_wdata,
    output logic [$clog2(MAX_WORD_LEN+1)-1:0]             len_rdata,
    output logic [COUNT_WIDTH-1:0]                        cnt_rdata,
    output logic [7:0]                                    chr_rdata
);

    localparam int LW = $clog2(MAX_WORD_LEN + 1);

    logic [7:0]             chr_mem [TABLE_DEPTH*MAX_WORD_LEN];
    logic [LW-1:0]          len_mem [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] cnt_mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we.chr_we)
        begin
            chr_mem[chr_addr] <= chr_wdata;
        end
        chr_rdata <= chr_mem[chr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we.len_we)
        begin
            len_mem[ent_addr] <= len_wdata;
        end
        len_rdata <= len_mem[ent_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we.cnt_we)
        begin
            cnt_mem[ent_addr] <= cnt_wdata;
        end
        cnt_rdata <= cnt_mem[ent_addr];
    end

endmodule

// ===== rtl/word_frequency_table.sv =====
// Word frequency table: splits a byte stream into words and counts them.
// Input channel (in_valid/in_ready) takes one word of the bus per handshake:
// a text byte (cmd 0) or a read of a table entry (cmd 1). The output channel
// (out_valid/out_ready) returns at most one result per input word.
// Ordinary text bytes give no result. A byte that ends a word with kept
// characters starts a walk over the stored entries under a small sequencer:
// S_LEN and S_LCMP per entry whose length differs, plus S_CRD and S_CCMP per
// compared character, all through one read port on each entry store. A hit
// passes S_HRD and S_HWR to bump the count. A miss with room writes length and
// count in S_LEN, then S_ARD and S_AWR copy each character; with the table full
// the word is dropped. A read of a stored entry passes S_RRD and S_RRES; a read
// of an entry not yet stored goes straight to S_OUT. Input is not ready while a
// walk or a read runs. S_OUT then moves the result into the output register,
// which holds it while the receiver stalls; a later byte that gives no result
// is still accepted meanwhile; the next result waits until that register frees.
// Reset empties the table and the word in progress at once; the entry stores
// need no clearing pass because only entries below the fill count are read.
module word_frequency_table #(
    parameter int MAX_WORD_LEN = 99,
    parameter int TABLE_DEPTH  = 256,
    parameter int COUNT_WIDTH  = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   cmd,
    input  logic [7:0]             text_byte,
    input  logic                   end_of_text,
    input  logic [7:0]             read_entry,
    input  logic [6:0]             read_char_pos,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             entry_index,
    output logic [COUNT_WIDTH-1:0] word_count,
    output logic                   newly_added,
    output logic                   dropped,
    output logic [6:0]             word_length,
    output logic [7:0]             char_out,
    output logic [8:0]             distinct_total
);

    localparam int LW = $clog2(MAX_WORD_LEN + 1);
    localparam int PW = $clog2(MAX_WORD_LEN);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int TW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = $clog2(TABLE_DEPTH * MAX_WORD_LEN);
    localparam int RW = (TW > 8) ? TW : 8;
    localparam int XW = (LW > 7) ? LW : 7;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_LEN  = 12'b000000000010,
        S_LCMP = 12'b000000000100,
        S_CRD  = 12'b000000001000,
        S_CCMP = 12'b000000010000,
        S_HRD  = 12'b000000100000,
        S_HWR  = 12'b000001000000,
        S_ARD  = 12'b000010000000,
        S_AWR  = 12'b000100000000,
        S_RRD  = 12'b001000000000,
        S_RRES = 12'b010000000000,
        S_OUT  = 12'b100000000000
    } state_t;

    state_t         state_reg, state_next;
    logic [LW-1:0]  raw_len_reg, raw_len_next;
    logic [LW-1:0]  filt_len_reg, filt_len_next;
    logic [LW-1:0]  wlen_reg, wlen_next;
    logic [LW-1:0]  pos_reg, pos_next;
    logic [6:0]     rpos_reg, rpos_next;
    logic [TW-1:0]  idx_reg, idx_next;
    logic [TW-1:0]  total_reg, total_next;
    logic [CW-1:0]  base_reg, base_next;
    logic           out_valid_reg, out_valid_next;

    logic [7:0]             res_idx_reg, res_idx_next;
    logic [COUNT_WIDTH-1:0] res_cnt_reg, res_cnt_next;
    logic                   res_added_reg, res_added_next;
    logic                   res_drop_reg, res_drop_next;
    logic [6:0]             res_len_reg, res_len_next;
    logic [7:0]             res_chr_reg, res_chr_next;

    logic [7:0]             out_idx_reg, out_idx_next;
    logic [COUNT_WIDTH-1:0] out_cnt_reg, out_cnt_next;
    logic                   out_added_reg, out_added_next;
    logic                   out_drop_reg, out_drop_next;
    logic [6:0]             out_len_reg, out_len_next;
    logic [7:0]             out_chr_reg, out_chr_next;
    logic [8:0]             out_total_reg, out_total_next;

    wft_pkg::wft_we_t       tbl_we;
    logic [IW-1:0]          ent_addr;
    logic [CW-1:0]          chr_addr;
    logic [LW-1:0]          len_wdata;
    logic [COUNT_WIDTH-1:0] cnt_wdata;
    logic [7:0]             chr_wdata;
    logic [LW-1:0]          len_rdata;
    logic [COUNT_WIDTH-1:0] cnt_rdata;
    logic [7:0]             chr_rdata;

    logic                   buf_we;
    logic [PW-1:0]          buf_waddr;
    logic [7:0]             buf_wdata;
    logic [7:0]             buf_rdata;

    logic                   byte_space;
    logic                   byte_plain;
    logic                   byte_upper;
    logic                   byte_store;
    logic [LW-1:0]          filt_inc;
    logic [LW-1:0]          raw_inc;
    logic [LW-1:0]          finish_len;
    logic                   finish;
    logic                   out_free;

    wft_buf #(
        .MAX_WORD_LEN(MAX_WORD_LEN)
    ) u_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .raddr (pos_reg[PW-1:0]),
        .rdata (buf_rdata)
    );

    wft_table #(
        .MAX_WORD_LEN(MAX_WORD_LEN),
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_table (
        .clk       (clk),
        .we        (tbl_we),
        .ent_addr  (ent_addr),
        .chr_addr  (chr_addr),
        .len_wdata (len_wdata),
        .cnt_wdata (cnt_wdata),
        .chr_wdata (chr_wdata),
        .len_rdata (len_rdata),
        .cnt_rdata (cnt_rdata),
        .chr_rdata (chr_rdata)
    );

    assign byte_space = wft_pkg::is_space(text_byte);
    assign byte_plain = wft_pkg::is_keep_plain(text_byte);
    assign byte_upper = wft_pkg::is_upper(text_byte);
    assign byte_store = (byte_plain || byte_upper) && (filt_len_reg < LW'(MAX_WORD_LEN));
    assign filt_inc   = filt_len_reg + LW'(byte_store);
    assign raw_inc    = raw_len_reg + LW'(1);
    assign out_free   = !out_valid_reg || out_ready;

    assign buf_waddr  = filt_len_reg[PW-1:0];
    assign buf_wdata  = byte_upper ? (text_byte + wft_pkg::CASE_OFFSET) : text_byte;
    assign ent_addr   = idx_reg[IW-1:0];
    assign chr_addr   = (state_reg == S_RRD) ? (base_reg + CW'(rpos_reg))
                                             : (base_reg + CW'(pos_reg));
    assign chr_wdata  = buf_rdata;

    always_comb
    begin
        state_next     = state_reg;
        raw_len_next   = raw_len_reg;
        filt_len_next  = filt_len_reg;
        wlen_next      = wlen_reg;
        pos_next       = pos_reg;
        rpos_next      = rpos_reg;
        idx_next       = idx_reg;
        total_next     = total_reg;
        base_next      = base_reg;
        res_idx_next   = res_idx_reg;
        res_cnt_next   = res_cnt_reg;
        res_added_next = res_added_reg;
        res_drop_next  = res_drop_reg;
        res_len_next   = res_len_reg;
        res_chr_next   = res_chr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_idx_next   = out_idx_reg;
        out_cnt_next   = out_cnt_reg;
        out_added_next = out_added_reg;
        out_drop_next  = out_drop_reg;
        out_len_next   = out_len_reg;
        out_chr_next   = out_chr_reg;
        out_total_next = out_total_reg;
        tbl_we         = '0;
        len_wdata      = wlen_reg;
        cnt_wdata      = COUNT_WIDTH'(1);
        buf_we         = 1'b0;
        finish         = 1'b0;
        finish_len     = filt_len_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (cmd)
                    begin
                        rpos_next    = read_char_pos;
                        res_idx_next = read_entry;
                        res_added_next = 1'b0;
                        res_drop_next  = 1'b0;
                        if (RW'(read_entry) >= RW'(total_reg))
                        begin
                            res_cnt_next = '0;
                            res_len_next = '0;
                            res_chr_next = '0;
                            state_next   = S_OUT;
                        end
                        else
                        begin
                            idx_next   = TW'(read_entry);
                            base_next  = CW'(read_entry) * CW'(MAX_WORD_LEN);
                            state_next = S_RRD;
                        end
                    end
                    else if (byte_space)
                    begin
                        finish     = (raw_len_reg != '0);
                        finish_len = filt_len_reg;
                    end
                    else
                    begin
                        buf_we        = byte_store;
                        raw_len_next  = raw_inc;
                        filt_len_next = filt_inc;
                        finish        = (raw_inc >= LW'(MAX_WORD_LEN)) || end_of_text;
                        finish_len    = filt_inc;
                    end
                    if (finish)
                    begin
                        raw_len_next  = '0;
                        filt_len_next = '0;
                        if (finish_len != '0)
                        begin
                            wlen_next  = finish_len;
                            idx_next   = '0;
                            base_next  = '0;
                            state_next = S_LEN;
                        end
                    end
                end
            end
            S_LEN:
            begin
                if (idx_reg == total_reg)
                begin
                    if (total_reg == TW'(TABLE_DEPTH))
                    begin
                        res_idx_next   = '0;
                        res_cnt_next   = '0;
                        res_added_next = 1'b0;
                        res_drop_next  = 1'b1;
                        res_len_next   = 7'(wlen_reg);
                        res_chr_next   = '0;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        // New entry: length and count go in now, the characters follow.
                        tbl_we.len_we = 1'b1;
                        tbl_we.cnt_we = 1'b1;
                        pos_next      = '0;
                        state_next    = S_ARD;
                    end
                end
                else
                begin
                    state_next = S_LCMP;
                end
            end
            S_LCMP:
            begin
                if (len_rdata == wlen_reg)
                begin
                    pos_next   = '0;
                    state_next = S_CRD;
                end
                else
                begin
                    idx_next   = idx_reg + TW'(1);
                    base_next  = base_reg + CW'(MAX_WORD_LEN);
                    state_next = S_LEN;
                end
            end
            S_CRD:
            begin
                state_next = S_CCMP;
            end
            S_CCMP:
            begin
                if (chr_rdata != buf_rdata)
                begin
                    idx_next   = idx_reg + TW'(1);
                    base_next  = base_reg + CW'(MAX_WORD_LEN);
                    state_next = S_LEN;
                end
                else if (pos_reg == (wlen_reg - LW'(1)))
                begin
                    state_next = S_HRD;
                end
                else
                begin
                    pos_next   = pos_reg + LW'(1);
                    state_next = S_CRD;
                end
            end
            S_HRD:
            begin
                state_next = S_HWR;
            end
            S_HWR:
            begin
                cnt_wdata      = (cnt_rdata == '1) ? cnt_rdata : (cnt_rdata + COUNT_WIDTH'(1));
                tbl_we.cnt_we  = 1'b1;
                res_idx_next   = 8'(idx_reg);
                res_cnt_next   = cnt_wdata;
                res_added_next = 1'b0;
                res_drop_next  = 1'b0;
                res_len_next   = 7'(wlen_reg);
                res_chr_next   = '0;
                state_next     = S_OUT;
            end
            S_ARD:
            begin
                state_next = S_AWR;
            end
            S_AWR:
            begin
                tbl_we.chr_we = 1'b1;
                if (pos_reg == (wlen_reg - LW'(1)))
                begin
                    total_next     = total_reg + TW'(1);
                    res_idx_next   = 8'(idx_reg);
                    res_cnt_next   = COUNT_WIDTH'(1);
                    res_added_next = 1'b1;
                    res_drop_next  = 1'b0;
                    res_len_next   = 7'(wlen_reg);
                    res_chr_next   = '0;
                    state_next     = S_OUT;
                end
                else
                begin
                    pos_next   = pos_reg + LW'(1);
                    state_next = S_ARD;
                end
            end
            S_RRD:
            begin
                state_next = S_RRES;
            end
            S_RRES:
            begin
                res_cnt_next = cnt_rdata;
                res_len_next = 7'(len_rdata);
                res_chr_next = (XW'(rpos_reg) < XW'(len_rdata)) ? chr_rdata : 8'h00;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = res_idx_reg;
                    out_cnt_next   = res_cnt_reg;
                    out_added_next = res_added_reg;
                    out_drop_next  = res_drop_reg;
                    out_len_next   = res_len_reg;
                    out_chr_next   = res_chr_reg;
                    out_total_next = 9'(total_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            raw_len_reg   <= '0;
            filt_len_reg  <= '0;
            total_reg     <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            raw_len_reg   <= raw_len_next;
            filt_len_reg  <= filt_len_next;
            total_reg     <= total_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wlen_reg      <= wlen_next;
        rpos_reg      <= rpos_next;
        base_reg      <= base_next;
        res_idx_reg   <= res_idx_next;
        res_cnt_reg   <= res_cnt_next;
        res_added_reg <= res_added_next;
        res_drop_reg  <= res_drop_next;
        res_len_reg   <= res_len_next;
        res_chr_reg   <= res_chr_next;
        out_idx_reg   <= out_idx_next;
        out_cnt_reg   <= out_cnt_next;
        out_added_reg <= out_added_next;
        out_drop_reg  <= out_drop_next;
        out_len_reg   <= out_len_next;
        out_chr_reg   <= out_chr_next;
        out_total_reg <= out_total_next;
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign entry_index    = out_idx_reg;
    assign word_count     = out_cnt_reg;
    assign newly_added    = out_added_reg;
    assign dropped        = out_drop_reg;
    assign word_length    = out_len_reg;
    assign char_out       = out_chr_reg;
    assign distinct_total = out_total_reg;

`include "word_frequency_table_assert.svh"

    `WFT_ASSERT(a_total_bound, total_reg <= TW'(TABLE_DEPTH), "entry count exceeds table depth")
    `WFT_ASSERT(a_drop_full, (out_valid_reg && out_drop_reg) |-> (total_reg == TW'(TABLE_DEPTH)), "word dropped while table has room")
    `WFT_ASSERT(a_add_xor_drop, !(out_valid_reg && out_added_reg && out_drop_reg), "result both added and dropped")
    `WFT_ASSERT_ALWAYS(a_filt_le_raw, filt_len_reg <= raw_len_reg, "filtered length exceeds raw length")

endmodule
